FILE: rtl/core/qkp_pkg.sv
package qkp_pkg;

  // Width of the wrapping target counter
  localparam int POS_BITS = 16;
  // Widths of the result and register fields
  localparam int OUT_POS_W = 16;
  localparam int STEP_W = 10;
  localparam int TICKS_W = 8;
  localparam int CMD_W = 3;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [STEP_W-1:0] COARSE_STEP_RST = STEP_W'(10);
  localparam logic [STEP_W-1:0] FINE_STEP_RST = STEP_W'(1);
  localparam logic [TICKS_W-1:0] LONG_PRESS_RST = TICKS_W'(16);
  localparam logic [TICKS_W-1:0] HOLD_MAX = '1;

  // Event codes
  localparam logic [CMD_W-1:0] CMD_A_CHG = 3'd0;
  localparam logic [CMD_W-1:0] CMD_B_CHG = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KEY_CHG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESYNC = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_WAIT_A_FALL = 3'd1,
    PH_WAIT_B_FALL = 3'd2,
    PH_WAIT_A_RISE = 3'd3,
    PH_WAIT_B_RISE = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic                 a_rising_armed;
    logic                 b_rising_armed;
    logic                 key_rising_armed;
    logic                 half_detent;
    logic [POS_BITS-1:0]  target;
    logic                 fine_mode;
    logic                 timer_on;
    logic [TICKS_W-1:0]   hold_count;
  } state_t;

  typedef struct packed {
    logic [STEP_W-1:0]  coarse_step;
    logic [STEP_W-1:0]  fine_step;
    logic [TICKS_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] position;
    logic [STEP_W-1:0]    step_size;
    logic                 changed;
    logic                 hold_timing;
  } result_t;

endpackage

FILE: rtl/core/qkp_step.sv
module qkp_step (
  input  qkp_pkg::state_t          st,
  input  qkp_pkg::cfg_t            cfg,
  input  logic [qkp_pkg::CMD_W-1:0] command,
  input  logic                     level_a,
  input  logic                     level_b,
  input  logic                     level_key,
  output qkp_pkg::state_t          st_next,
  output qkp_pkg::result_t         res
);
  import qkp_pkg::*;

  logic                is_a;
  logic                own;
  logic                other;
  logic                own_n;
  logic                other_n;
  logic                lvl;
  logic                changed;
  phase_t              wait_fall;
  phase_t              wait_rise;
  phase_t              go_fall;
  phase_t              go_rise;
  logic [STEP_W-1:0]   step;
  logic [TICKS_W-1:0]  hc;

  // Select the roles of the two phase pins for this edge
  always_comb begin
    is_a      = (command == CMD_A_CHG);
    own       = is_a ? st.a_rising_armed : st.b_rising_armed;
    other     = is_a ? st.b_rising_armed : st.a_rising_armed;
    lvl       = is_a ? level_a : level_b;
    wait_fall = is_a ? PH_WAIT_A_FALL : PH_WAIT_B_FALL;
    wait_rise = is_a ? PH_WAIT_A_RISE : PH_WAIT_B_RISE;
    go_fall   = is_a ? PH_WAIT_B_FALL : PH_WAIT_A_FALL;
    go_rise   = is_a ? PH_WAIT_B_RISE : PH_WAIT_A_RISE;
    step      = st.fine_mode ? cfg.fine_step : cfg.coarse_step;
  end

  // Work out the next state for one event
  always_comb begin
    st_next = st;
    changed = 1'b0;
    own_n   = own;
    other_n = other;
    hc      = st.hold_count;
    unique case (command)
      CMD_A_CHG, CMD_B_CHG: begin
        if (lvl == own) begin
          if (st.phase == wait_fall || st.phase == wait_rise) begin
            // Second pin of a half-detent: count only with the expected polarity
            if (own == (st.phase == wait_rise)) begin
              st_next.phase = PH_IDLE;
              own_n = ~own;
              if (st.half_detent) begin
                st_next.half_detent = 1'b0;
                changed = 1'b1;
                if (is_a) begin
                  st_next.target = st.target + POS_BITS'(step);
                end else begin
                  st_next.target = st.target - POS_BITS'(step);
                end
              end else begin
                st_next.half_detent = 1'b1;
              end
            end
          end else if (st.phase == go_fall || st.phase == go_rise) begin
            // Same pin again: drop back to idle
            st_next.phase = PH_IDLE;
            own_n = ~own;
          end else begin
            // Idle: start a half-detent
            st_next.phase = own ? go_rise : go_fall;
            other_n = own;
            own_n = ~own;
          end
          if (is_a) begin
            st_next.a_rising_armed = own_n;
            st_next.b_rising_armed = other_n;
          end else begin
            st_next.b_rising_armed = own_n;
            st_next.a_rising_armed = other_n;
          end
        end
      end
      CMD_KEY_CHG: begin
        if (level_key == st.key_rising_armed) begin
          if (!level_key) begin
            st_next.fine_mode = ~st.fine_mode;
            st_next.hold_count = '0;
            st_next.timer_on = 1'b1;
            st_next.key_rising_armed = 1'b1;
            changed = 1'b1;
          end else begin
            st_next.timer_on = 1'b0;
            st_next.key_rising_armed = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        if (st.timer_on) begin
          // Advance the hold count, saturating
          if (st.hold_count != HOLD_MAX) begin
            hc = st.hold_count + TICKS_W'(1);
          end
          st_next.hold_count = hc;
          if (hc >= cfg.long_press_ticks) begin
            st_next.timer_on = 1'b0;
            st_next.target = '0;
            st_next.fine_mode = 1'b0;
            changed = 1'b1;
          end
        end
      end
      CMD_RESYNC: begin
        st_next.phase = PH_IDLE;
        st_next.half_detent = 1'b0;
        st_next.fine_mode = 1'b0;
        changed = st.fine_mode;
        st_next.a_rising_armed = ~level_a;
        st_next.b_rising_armed = ~level_b;
      end
      default: begin
      end
    endcase
  end

  // Build the result from the updated state
  always_comb begin
    res.position    = OUT_POS_W'(signed'(st_next.target));
    res.step_size   = st_next.fine_mode ? cfg.fine_step : cfg.coarse_step;
    res.changed     = changed;
    res.hold_timing = st_next.timer_on;
  end

endmodule

FILE: rtl/core/quadrature_knob_position_core.sv
// Quadrature knob position core.
// Input channel (in_valid/in_ready): one event per request; command selects an
// A change, B change, key change, timer tick or resync, and level_a, level_b and
// level_key carry the present pin levels.
// Output channel (out_valid/out_ready): exactly one result per request with the
// wrapped target position, the step in use, a changed flag and the hold timer
// state.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 coarse step, 1 fine step,
// 2 long-press tick count; always ready. Write only while no request is in flight.
// The result is registered; while the receiver stalls it waits in the skid register.
// Throughput: one request per cycle while in_ready is high. The event update is one pass of logic
// between the state register and the result register.
// A two-entry output stage (result register plus skid register) absorbs a
// stalled receiver: in_ready drops only once both entries are full, and comes
// back from a register, not from out_ready.
// Reset: position 0, coarse mode, idle phase, falling edges armed on A, B and
// the key, timer stopped, registers at 10, 1 and 16, output empty.
module quadrature_knob_position_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [qkp_pkg::CMD_W-1:0]          command,
  input  logic                               level_a,
  input  logic                               level_b,
  input  logic                               level_key,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qkp_pkg::OUT_POS_W-1:0] position,
  output logic [qkp_pkg::STEP_W-1:0]         step_size,
  output logic                               changed,
  output logic                               hold_timing,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qkp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qkp_pkg::STEP_W-1:0]         cfg_data
);
  import qkp_pkg::*;

  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  result_t res_next;
  result_t res_q;
  result_t skid_q;
  logic    skid_valid;
  logic    in_acc;
  logic    out_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid;
  assign in_acc    = in_valid & in_ready;
  assign out_pop   = out_valid & out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coarse_step      <= COARSE_STEP_RST;
      cfg.fine_step        <= FINE_STEP_RST;
      cfg.long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COARSE_STEP: cfg.coarse_step <= cfg_data;
        REG_FINE_STEP:   cfg.fine_step <= cfg_data;
        REG_LONG_PRESS:  cfg.long_press_ticks <= cfg_data[TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qkp_step u_step (
    .st        (st),
    .cfg       (cfg),
    .command   (command),
    .level_a   (level_a),
    .level_b   (level_b),
    .level_key (level_key),
    .st_next   (st_next),
    .res       (res_next)
  );

  // Decoder state: advance on every taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, target: '0, hold_count: '0, default: 1'b0};
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_pop) begin
      if (skid_valid) begin
        res_q <= skid_q;
      end else if (in_acc) begin
        res_q <= res_next;
      end
    end else if (in_acc) begin
      skid_q <= res_next;
    end
  end

  assign position    = signed'(res_q.position);
  assign step_size   = res_q.step_size;
  assign changed     = res_q.changed;
  assign hold_timing = res_q.hold_timing;

  // The skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // A held skid entry keeps its result until the output drains
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> (skid_valid && $stable(skid_q)))
    else $error("skid entry lost or changed during stall");

  // After every taken request the output holds a valid result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("request taken but no result presented");

  // A tick with the timer stopped leaves position and mode alone
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (in_acc && command == CMD_TICK && !st.timer_on) |=>
      ($stable(st.target) && $stable(st.fine_mode)))
    else $error("tick with stopped timer changed state");

  // A completed long press clears the position
  a_long_press_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && command == CMD_TICK && st.timer_on && !st_next.timer_on) |=>
      (st.target == '0 && !st.fine_mode))
    else $error("long press did not clear position");

endmodule

FILE: tb/sv/quadrature_knob_position_core_tb.sv
`timescale 1ns / 100ps

module quadrature_knob_position_core_tb;
  import qkp_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 12;
  localparam int SPIN_EDGES = 140;
  localparam int HOLD_TICKS_MAX = 255;

  // Event codes that the block must ignore
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Results that can be read off directly
  localparam result_t R_NONE = '0;
  localparam result_t R_QUIET = '{16'h0000, 10'd10, 1'b0, 1'b0};
  localparam result_t R_DOWN = '{16'hFFF6, 10'd10, 1'b1, 1'b0};
  localparam result_t R_COARSE_CHG = '{16'h0000, 10'd10, 1'b1, 1'b0};
  localparam result_t R_FINE_PRESS = '{16'h0000, 10'd1, 1'b1, 1'b1};

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             la;
    logic             lb;
    logic             lk;
    logic             typed;
    result_t          want;
  } probe_row_t;

  // Directed events; long-press limit is 2 while these run
  localparam probe_row_t KNOB_PROBES [25] = '{
    '{CMD_TICK,     1'b0, 1'b0, 1'b1, 1'b1, R_QUIET},      // tick with timer off
    '{CMD_RSVD_LO,  1'b0, 1'b0, 1'b0, 1'b1, R_QUIET},      // unknown commands
    '{CMD_RSVD_MID, 1'b1, 1'b0, 1'b1, 1'b1, R_QUIET},
    '{CMD_RSVD_HI,  1'b1, 1'b1, 1'b1, 1'b1, R_QUIET},
    '{CMD_A_CHG,    1'b1, 1'b1, 1'b1, 1'b1, R_QUIET},      // A edge not armed
    '{CMD_A_CHG,    1'b0, 1'b1, 1'b1, 1'b1, R_QUIET},      // detent down, A led
    '{CMD_B_CHG,    1'b0, 1'b0, 1'b1, 1'b1, R_QUIET},
    '{CMD_A_CHG,    1'b1, 1'b0, 1'b1, 1'b1, R_QUIET},
    '{CMD_B_CHG,    1'b1, 1'b1, 1'b1, 1'b1, R_DOWN},
    '{CMD_B_CHG,    1'b1, 1'b0, 1'b1, 1'b0, R_NONE},       // detent up, B led
    '{CMD_A_CHG,    1'b0, 1'b0, 1'b1, 1'b0, R_NONE},
    '{CMD_B_CHG,    1'b0, 1'b1, 1'b1, 1'b0, R_NONE},
    '{CMD_A_CHG,    1'b1, 1'b1, 1'b1, 1'b1, R_COARSE_CHG},
    '{CMD_A_CHG,    1'b0, 1'b0, 1'b1, 1'b0, R_NONE},       // A again while waiting for B
    '{CMD_A_CHG,    1'b1, 1'b0, 1'b1, 1'b0, R_NONE},
    '{CMD_KEY_CHG,  1'b1, 1'b0, 1'b0, 1'b1, R_FINE_PRESS}, // press, tick, release
    '{CMD_TICK,     1'b1, 1'b0, 1'b0, 1'b0, R_NONE},
    '{CMD_KEY_CHG,  1'b1, 1'b0, 1'b1, 1'b0, R_NONE},
    '{CMD_KEY_CHG,  1'b1, 1'b0, 1'b1, 1'b0, R_NONE},       // key edge not armed
    '{CMD_RESYNC,   1'b1, 1'b0, 1'b1, 1'b1, R_COARSE_CHG}, // resync leaves fine mode
    '{CMD_RESYNC,   1'b1, 1'b0, 1'b1, 1'b0, R_NONE},
    '{CMD_KEY_CHG,  1'b1, 1'b0, 1'b0, 1'b1, R_FINE_PRESS}, // hold until long press
    '{CMD_TICK,     1'b1, 1'b0, 1'b0, 1'b0, R_NONE},
    '{CMD_TICK,     1'b1, 1'b0, 1'b0, 1'b1, R_COARSE_CHG},
    '{CMD_KEY_CHG,  1'b1, 1'b0, 1'b1, 1'b0, R_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] command = '0;
  logic level_a = 1'b0;
  logic level_b = 1'b0;
  logic level_key = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_POS_W-1:0] position;
  logic [STEP_W-1:0] step_size;
  logic changed;
  logic hold_timing;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;

  // Knob model state and its register copies
  phase_t knob_phase = PH_IDLE;
  logic a_arm_rise = 1'b0;
  logic b_arm_rise = 1'b0;
  logic key_arm_rise = 1'b0;
  logic half_det = 1'b0;
  logic [POS_BITS-1:0] target_pos = '0;
  logic fine_sel = 1'b0;
  logic hold_on = 1'b0;
  logic [TICKS_W-1:0] hold_ticks = '0;
  logic [STEP_W-1:0] coarse_reg = COARSE_STEP_RST;
  logic [STEP_W-1:0] fine_reg = FINE_STEP_RST;
  logic [TICKS_W-1:0] long_reg = LONG_PRESS_RST;

  // Physical pin levels behind the random stimulus
  logic pin_a = 1'b0;
  logic pin_b = 1'b0;
  logic pin_key = 1'b1;
  logic [1:0] gray_idx = 2'd0;
  logic turn_dir = 1'b1;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  result_t knob_reports_due [$];

  quadrature_knob_position_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .level_a     (level_a),
    .level_b     (level_b),
    .level_key   (level_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .step_size   (step_size),
    .changed     (changed),
    .hold_timing (hold_timing),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [STEP_W-1:0] active_step();
    return fine_sel ? fine_reg : coarse_reg;
  endfunction

  // Count one half-detent; report a completed detent
  function automatic logic turn_half(input logic up);
    if (half_det) begin
      half_det = 1'b0;
      if (up) begin
        target_pos = target_pos + POS_BITS'(active_step());
      end else begin
        target_pos = target_pos - POS_BITS'(active_step());
      end
      return 1'b1;
    end
    half_det = 1'b1;
    return 1'b0;
  endfunction

  // Advance the phase machine on an accepted edge of one pin
  function automatic logic pin_edge(input logic is_a, inout logic own, inout logic other);
    phase_t own_fall, own_rise, hand_fall, hand_rise;
    logic done;
    own_fall = is_a ? PH_WAIT_A_FALL : PH_WAIT_B_FALL;
    own_rise = is_a ? PH_WAIT_A_RISE : PH_WAIT_B_RISE;
    hand_fall = is_a ? PH_WAIT_B_FALL : PH_WAIT_A_FALL;
    hand_rise = is_a ? PH_WAIT_B_RISE : PH_WAIT_A_RISE;
    done = 1'b0;
    if (knob_phase == own_fall) begin
      if (!own) begin
        done = turn_half(is_a);
        knob_phase = PH_IDLE;
        own = 1'b1;
      end
    end else if (knob_phase == own_rise) begin
      if (own) begin
        done = turn_half(is_a);
        knob_phase = PH_IDLE;
        own = 1'b0;
      end
    end else if (knob_phase == hand_fall || knob_phase == hand_rise) begin
      // wrong pin: drop back to idle and flip this pin's polarity
      knob_phase = PH_IDLE;
      own = ~own;
    end else if (!own) begin
      knob_phase = hand_fall;
      other = 1'b0;
      own = 1'b1;
    end else begin
      knob_phase = hand_rise;
      other = 1'b1;
      own = 1'b0;
    end
    return done;
  endfunction

  // Apply one event to the knob model and return the reading it produces
  function automatic result_t decode_knob_event(input logic [CMD_W-1:0] cmd,
                                                input logic la, input logic lb,
                                                input logic lk);
    result_t r;
    logic chg;
    chg = 1'b0;
    case (cmd)
      CMD_A_CHG: begin
        if (la == a_arm_rise) chg = pin_edge(1'b1, a_arm_rise, b_arm_rise);
      end
      CMD_B_CHG: begin
        if (lb == b_arm_rise) chg = pin_edge(1'b0, b_arm_rise, a_arm_rise);
      end
      CMD_KEY_CHG: begin
        if (lk == key_arm_rise) begin
          if (!lk) begin
            fine_sel = ~fine_sel;
            hold_ticks = '0;
            hold_on = 1'b1;
            key_arm_rise = 1'b1;
            chg = 1'b1;
          end else begin
            hold_on = 1'b0;
            key_arm_rise = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        if (hold_on) begin
          if (hold_ticks != HOLD_MAX) hold_ticks++;
          if (hold_ticks >= long_reg) begin
            hold_on = 1'b0;
            target_pos = '0;
            fine_sel = 1'b0;
            chg = 1'b1;
          end
        end
      end
      CMD_RESYNC: begin
        knob_phase = PH_IDLE;
        half_det = 1'b0;
        chg = fine_sel;
        fine_sel = 1'b0;
        a_arm_rise = ~la;
        b_arm_rise = ~lb;
      end
      default: begin
      end
    endcase
    r.position = OUT_POS_W'(signed'(target_pos));
    r.step_size = active_step();
    r.changed = chg;
    r.hold_timing = hold_on;
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Issue one request and queue the reading it should produce
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic la, input logic lb,
                            input logic lk, input logic typed, input result_t typed_want);
    int unsigned gap;
    result_t pred;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    level_a <= la;
    level_b <= lb;
    level_key <= lk;
    do @(posedge clk); while (!in_ready);
    pred = decode_knob_event(cmd, la, lb, lk);
    knob_reports_due.push_back(typed ? typed_want : pred);
  endtask

  // Hold off requests until every reading is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (knob_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COARSE_STEP: coarse_reg = data;
      REG_FINE_STEP: fine_reg = data;
      REG_LONG_PRESS: long_reg = data[TICKS_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Move the knob one quadrature state in the current direction
  task automatic turn_knob();
    logic [1:0] next_idx;
    logic na;
    logic nb;
    next_idx = turn_dir ? gray_idx + 2'd1 : gray_idx - 2'd1;
    nb = next_idx[1];
    na = next_idx[1] ^ next_idx[0];
    gray_idx = next_idx;
    if (na != pin_a) begin
      pin_a = na;
      send_event(CMD_A_CHG, pin_a, pin_b, pin_key, 1'b0, R_NONE);
    end else begin
      pin_b = nb;
      send_event(CMD_B_CHG, pin_a, pin_b, pin_key, 1'b0, R_NONE);
    end
  endtask

  // Mostly clean rotation, with key activity, ticks, resyncs and noise
  task automatic send_random();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 62) begin
      if ($urandom_range(15) == 0) turn_dir = ~turn_dir;
      turn_knob();
    end else if (pick < 72) begin
      if ($urandom_range(4) != 0) pin_key = ~pin_key;
      send_event(CMD_KEY_CHG, pin_a, pin_b, pin_key, 1'b0, R_NONE);
    end else if (pick < 88) begin
      send_event(CMD_TICK, pin_a, pin_b, pin_key, 1'b0, R_NONE);
    end else if (pick < 92) begin
      send_event(CMD_RESYNC, pin_a, pin_b, pin_key, 1'b0, R_NONE);
    end else begin
      send_event(CMD_W'($urandom_range(CMD_RSVD_HI)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, R_NONE);
    end
  endtask

  // Stall the receiver in bursts
  initial begin : rx_pacing
    int unsigned span;
    @(posedge clk);
    forever begin
      span = rx_steady ? 0 : pick_gap();
      if (span != 0) begin
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Compare each reading with the oldest one outstanding
  task automatic note_mismatch(input string field, input int want_v, input int got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin : reading_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (knob_reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: reading with no request outstanding, position %0d", $time, position);
      end else begin
        want = knob_reports_due.pop_front();
        if (position !== want.position)
          note_mismatch("position", int'($signed(want.position)), int'(position));
        if (step_size !== want.step_size)
          note_mismatch("step_size", int'(want.step_size), int'(step_size));
        if (changed !== want.changed)
          note_mismatch("changed", int'(want.changed), int'(changed));
        if (hold_timing !== want.hold_timing)
          note_mismatch("hold_timing", int'(want.hold_timing), int'(hold_timing));
      end
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    write_reg(REG_LONG_PRESS, STEP_W'(2));
    for (int i = 0; i < $size(KNOB_PROBES); i++) begin
      send_event(KNOB_PROBES[i].cmd, KNOB_PROBES[i].la, KNOB_PROBES[i].lb,
                 KNOB_PROBES[i].lk, KNOB_PROBES[i].typed, KNOB_PROBES[i].want);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      tx_steady = (p == 0) || ($urandom_range(2) == 0);
      rx_steady = (p == 0) || ($urandom_range(2) == 0);
      case (p)
        0: begin
          write_reg(REG_COARSE_STEP, STEP_W'(1000));
          write_reg(REG_FINE_STEP, STEP_W'(1));
          write_reg(REG_LONG_PRESS, STEP_W'(1));
        end
        1: begin
          write_reg(REG_COARSE_STEP, STEP_W'(1));
          write_reg(REG_FINE_STEP, STEP_W'(1000));
          write_reg(REG_LONG_PRESS, STEP_W'(255));
        end
        2: begin
          write_reg(REG_COARSE_STEP, '0);
          write_reg(REG_FINE_STEP, '0);
          write_reg(REG_LONG_PRESS, '0);
          write_reg(REG_UNUSED, STEP_W'($urandom_range(1023)));
        end
        3: begin
          write_reg(REG_COARSE_STEP, STEP_W'(1023));
          write_reg(REG_FINE_STEP, STEP_W'(512));
          write_reg(REG_LONG_PRESS, STEP_W'(10'h305));
        end
        default: begin
          write_reg(REG_COARSE_STEP, STEP_W'($urandom_range(1, 1000)));
          write_reg(REG_FINE_STEP, STEP_W'($urandom_range(1, 1000)));
          write_reg(REG_LONG_PRESS, STEP_W'($urandom_range(1, 24)));
        end
      endcase
      send_event(CMD_RESYNC, pin_a, pin_b, pin_key, 1'b0, R_NONE);

      // Spin far enough in one direction to wrap the position
      if (p == 0) begin
        turn_dir = 1'($urandom_range(1));
        repeat (SPIN_EDGES) turn_knob();
      end

      // Hold the key through the longest long-press limit
      if (p == 1) begin
        pin_key = 1'b1;
        send_event(CMD_KEY_CHG, pin_a, pin_b, pin_key, 1'b0, R_NONE);
        pin_key = 1'b0;
        send_event(CMD_KEY_CHG, pin_a, pin_b, pin_key, 1'b0, R_NONE);
        repeat (HOLD_TICKS_MAX) send_event(CMD_TICK, pin_a, pin_b, pin_key, 1'b0, R_NONE);
        pin_key = 1'b1;
        send_event(CMD_KEY_CHG, pin_a, pin_b, pin_key, 1'b0, R_NONE);
      end

      repeat (ITEMS_PER_PHASE) send_random();
    end

    settle();
    if (mismatch_count == 0 && knob_reports_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
